@@ rtl/rfbp_pkg.sv @@
// ----------------------------------------------------------------------------
// rfbp_pkg: shared types and codes of the frame buffer pool
// Field widths, item kinds, result codes and the controller/datapath links.
// ----------------------------------------------------------------------------
package rfbp_pkg;

    localparam int KIND_W = 2;
    localparam int CAM_W  = 3;
    localparam int GRP_W  = 2;
    localparam int WRK_W  = 3;
    localparam int SLOT_W = 9;
    localparam int STAT_W = 2;
    localparam int REFS_W = 2;

    localparam logic [KIND_W-1:0] KIND_PRODUCE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FETCH   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID  = 2'd2;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic sweep;
        logic accept;
        logic check;
        logic scan;
        logic fetch;
        logic fref;
        logic commit;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic is_produce;
        logic is_fetch;
        logic is_release;
        logic bad;
        logic prod_fail;
        logic scan_hit;
        logic scan_last;
        logic out_busy;
    } sts_t;

endpackage

@@ rtl/refcounted_frame_buffer_pool_unit.sv @@
// ----------------------------------------------------------------------------
// refcounted_frame_buffer_pool_unit: reference-counted frame buffer pool
// Per-camera free rings and per-group FIFOs of frame slots with counts.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one transaction: produce, fetch
// or release. Output channel (out_valid/out_ready) returns exactly one result
// per transaction: status, slot_out, freed and refs_left.
// Steps: produce and release pass a check and a commit step before out_valid,
// a rejected transaction only the check; fetch passes the check, then a
// round-robin scan that probes one camera FIFO per step, then, on a hit, a group
// FIFO read and a reference count read.
// One transaction is in flight at a time; in_ready rises again once the
// result has moved into the output register, so no new transaction is
// accepted before the last one's result has been registered.
// After reset the block sweeps the free ring and reference count memories,
// one entry per cycle, NUM_CAMS * SLOTS_PER_CAM entries (384 by default),
// with in_ready low.
// A stalled receiver holds the output register; one more transaction may be
// accepted and processed, and its result waits until the output drains.
// ----------------------------------------------------------------------------
module refcounted_frame_buffer_pool_unit #(
    parameter int NUM_CAMS      = 6,
    parameter int SLOTS_PER_CAM = 64,
    parameter int NUM_GROUPS    = 3,
    parameter int MAX_WORKERS   = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [rfbp_pkg::KIND_W-1:0]  kind,
    input  logic [rfbp_pkg::CAM_W-1:0]   camera,
    input  logic [rfbp_pkg::GRP_W-1:0]   group,
    input  logic [rfbp_pkg::WRK_W-1:0]   worker,
    input  logic [rfbp_pkg::SLOT_W-1:0]  slot_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [rfbp_pkg::STAT_W-1:0]  status,
    output logic [rfbp_pkg::SLOT_W-1:0]  slot_out,
    output logic                         freed,
    output logic [rfbp_pkg::REFS_W-1:0]  refs_left
);
    import rfbp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rfbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    rfbp_dp #(
        .NUM_CAMS      (NUM_CAMS),
        .SLOTS_PER_CAM (SLOTS_PER_CAM),
        .NUM_GROUPS    (NUM_GROUPS),
        .MAX_WORKERS   (MAX_WORKERS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .kind      (kind),
        .camera    (camera),
        .group     (group),
        .worker    (worker),
        .slot_in   (slot_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .slot_out  (slot_out),
        .freed     (freed),
        .refs_left (refs_left)
    );

endmodule

@@ rtl/rfbp_ram.sv @@
// ----------------------------------------------------------------------------
// rfbp_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rfbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/rfbp_ctrl.sv @@
// ----------------------------------------------------------------------------
// rfbp_ctrl: sequencing state machine of the frame buffer pool
// Runs the clearing sweep, then steps each transaction through check and, unless
// rejected, scan and on a hit fetch and fref, or commit; fills the output register.
// ----------------------------------------------------------------------------
module rfbp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output rfbp_pkg::cmd_t cmd,
    input  rfbp_pkg::sts_t sts
);
    import rfbp_pkg::*;

    typedef enum logic [7:0] {
        S_SWEEP  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_CHECK  = 8'b0000_0100,
        S_SCAN   = 8'b0000_1000,
        S_FETCH  = 8'b0001_0000,
        S_FREF   = 8'b0010_0000,
        S_COMMIT = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (sts.bad || (sts.is_produce && sts.prod_fail))
                begin
                    state_next = S_DONE;
                end
                else if (sts.is_fetch)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_hit)
                begin
                    state_next = S_FETCH;
                end
                else if (sts.scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_FREF;
            end
            S_FREF:
            begin
                cmd.fref   = 1'b1;
                state_next = S_DONE;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_SWEEP;
            end
        endcase
    end

endmodule

@@ rtl/rfbp_dp.sv @@
// ----------------------------------------------------------------------------
// rfbp_dp: datapath of the frame buffer pool
// Ring pointers, round-robin pointers, the free ring, group FIFO and
// reference count memories, and the result and output registers.
// ----------------------------------------------------------------------------
module rfbp_dp #(
    parameter int NUM_CAMS      = 6,
    parameter int SLOTS_PER_CAM = 64,
    parameter int NUM_GROUPS    = 3,
    parameter int MAX_WORKERS   = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rfbp_pkg::cmd_t               cmd,
    output rfbp_pkg::sts_t               sts,
    input  logic [rfbp_pkg::KIND_W-1:0]  kind,
    input  logic [rfbp_pkg::CAM_W-1:0]   camera,
    input  logic [rfbp_pkg::GRP_W-1:0]   group,
    input  logic [rfbp_pkg::WRK_W-1:0]   worker,
    input  logic [rfbp_pkg::SLOT_W-1:0]  slot_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [rfbp_pkg::STAT_W-1:0]  status,
    output logic [rfbp_pkg::SLOT_W-1:0]  slot_out,
    output logic                         freed,
    output logic [rfbp_pkg::REFS_W-1:0]  refs_left
);
    import rfbp_pkg::*;

    localparam int TOTAL = NUM_CAMS * SLOTS_PER_CAM;
    localparam int AW    = $clog2(TOTAL);
    localparam int SW    = $clog2(SLOTS_PER_CAM);
    localparam int PW    = $clog2(2 * SLOTS_PER_CAM);
    localparam int CW    = (NUM_CAMS > 1) ? $clog2(NUM_CAMS) : 1;
    localparam int GW    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int NRR   = NUM_GROUPS * MAX_WORKERS;
    localparam int RW    = (NRR > 1) ? $clog2(NRR) : 1;

    function automatic logic [SW-1:0] ring_idx(input logic [PW-1:0] x);
        ring_idx = (x >= PW'(SLOTS_PER_CAM)) ? SW'(x - PW'(SLOTS_PER_CAM)) : SW'(x);
    endfunction

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] x);
        ptr_inc = (x == PW'(2 * SLOTS_PER_CAM - 1)) ? '0 : x + 1'b1;
    endfunction

    function automatic logic is_full(input logic [PW-1:0] h, input logic [PW-1:0] t);
        logic [PW:0] occ;
        if (t >= h)
            occ = {1'b0, t} - {1'b0, h};
        else
            occ = {1'b0, t} + (PW+1)'(2 * SLOTS_PER_CAM) - {1'b0, h};
        is_full = (occ >= (PW+1)'(SLOTS_PER_CAM));
    endfunction

    logic [PW-1:0] free_head_reg [NUM_CAMS];
    logic [PW-1:0] free_tail_reg [NUM_CAMS];
    logic [PW-1:0] grp_head_reg  [NUM_CAMS][NUM_GROUPS];
    logic [PW-1:0] grp_tail_reg  [NUM_CAMS][NUM_GROUPS];
    logic [CW-1:0] rr_reg        [NRR];

    logic [AW-1:0]     sw_addr_reg;
    logic [SW-1:0]     sw_idx_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [GW-1:0]     grp_reg;
    logic [SLOT_W-1:0] sid_reg;
    logic              bad_reg;
    logic [CW-1:0]     cam_reg;
    logic [RW-1:0]     rr_idx_reg;
    logic [CW-1:0]     k_reg;
    logic [AW-1:0]     gid_reg;

    logic [STAT_W-1:0] res_status_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic              res_freed_reg;
    logic [REFS_W-1:0] res_refs_reg;

    logic              out_valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [SLOT_W-1:0] slot_out_reg;
    logic              freed_reg;
    logic [REFS_W-1:0] refs_left_reg;

    logic [SW-1:0]     free_rdata;
    logic [REFS_W-1:0] ref_rdata;
    logic [SW-1:0]     grp_rdata [NUM_GROUPS];

    logic              is_produce, is_fetch, is_release;
    logic [PW-1:0]     fh, ft, sel_gh, sel_gt;
    logic              free_empty, free_full, grp_full;
    logic [AW-1:0]     cam_base, fetch_gid, prod_gid;
    logic [CW-1:0]     cam_next;
    logic              prod_commit, rel_commit;

    logic              acc_bad;
    logic [CW-1:0]     acc_cam, rel_cam;
    logic [RW-1:0]     acc_rr;

    logic              free_we, ref_we;
    logic [AW-1:0]     free_waddr, free_raddr, ref_waddr, ref_raddr;
    logic [SW-1:0]     free_wdata;
    logic [REFS_W-1:0] ref_wdata;
    logic [AW-1:0]     grp_waddr [NUM_GROUPS];
    logic [AW-1:0]     grp_raddr;

    assign is_produce = (kind_reg == KIND_PRODUCE);
    assign is_fetch   = (kind_reg == KIND_FETCH);
    assign is_release = (kind_reg == KIND_RELEASE);

    assign fh         = free_head_reg[cam_reg];
    assign ft         = free_tail_reg[cam_reg];
    assign free_empty = (fh == ft);
    assign free_full  = is_full(fh, ft);
    assign sel_gh     = grp_head_reg[cam_reg][grp_reg];
    assign sel_gt     = grp_tail_reg[cam_reg][grp_reg];
    assign cam_base   = AW'(cam_reg) * AW'(SLOTS_PER_CAM);
    assign fetch_gid  = cam_base + AW'(grp_rdata[grp_reg]);
    assign prod_gid   = cam_base + AW'(free_rdata);
    assign cam_next   = (cam_reg == CW'(NUM_CAMS - 1)) ? '0 : cam_reg + 1'b1;

    always_comb
    begin
        grp_full = 1'b0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            if (is_full(grp_head_reg[cam_reg][g], grp_tail_reg[cam_reg][g]))
            begin
                grp_full = 1'b1;
            end
        end
    end

    always_comb
    begin
        rel_cam = '0;
        for (int c = 1; c < NUM_CAMS; c++)
        begin
            if (32'(slot_in) >= 32'(c * SLOTS_PER_CAM))
            begin
                rel_cam = rel_cam + 1'b1;
            end
        end
    end

    always_comb
    begin
        acc_bad = 1'b0;
        acc_cam = '0;
        acc_rr  = '0;
        case (kind)
            KIND_PRODUCE:
            begin
                if (32'(camera) >= 32'(NUM_CAMS))
                    acc_bad = 1'b1;
                else
                    acc_cam = CW'(camera);
            end
            KIND_FETCH:
            begin
                if (32'(group) >= 32'(NUM_GROUPS) || 32'(worker) >= 32'(MAX_WORKERS))
                    acc_bad = 1'b1;
                else
                begin
                    acc_rr  = RW'(32'(group) * 32'(MAX_WORKERS) + 32'(worker));
                    acc_cam = rr_reg[acc_rr];
                end
            end
            KIND_RELEASE:
            begin
                if (32'(slot_in) >= 32'(TOTAL))
                    acc_bad = 1'b1;
                else
                    acc_cam = rel_cam;
            end
            default:
            begin
                acc_bad = 1'b1;
            end
        endcase
    end

    assign prod_commit = cmd.commit && is_produce;
    assign rel_commit  = cmd.commit && is_release;

    always_comb
    begin
        free_we    = cmd.sweep;
        free_waddr = sw_addr_reg;
        free_wdata = sw_idx_reg;
        ref_we     = cmd.sweep;
        ref_waddr  = sw_addr_reg;
        ref_wdata  = '0;
        if (prod_commit)
        begin
            ref_we    = 1'b1;
            ref_waddr = prod_gid;
            ref_wdata = REFS_W'(NUM_GROUPS);
        end
        else if (rel_commit)
        begin
            ref_waddr = AW'(sid_reg);
            if (ref_rdata == REFS_W'(1))
            begin
                if (!free_full)
                begin
                    ref_we     = 1'b1;
                    free_we    = 1'b1;
                    free_waddr = cam_base + AW'(ring_idx(ft));
                    free_wdata = SW'(AW'(sid_reg) - cam_base);
                end
            end
            else if (ref_rdata != '0)
            begin
                ref_we    = 1'b1;
                ref_wdata = ref_rdata - 1'b1;
            end
        end
    end

    assign free_raddr = cam_base + AW'(ring_idx(fh));
    assign ref_raddr  = cmd.fetch ? fetch_gid : AW'(sid_reg);
    assign grp_raddr  = cam_base + AW'(ring_idx(sel_gh));

    rfbp_ram #(.WIDTH(SW), .DEPTH(TOTAL)) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .raddr (free_raddr),
        .rdata (free_rdata)
    );

    rfbp_ram #(.WIDTH(REFS_W), .DEPTH(TOTAL)) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (ref_wdata),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    for (genvar g = 0; g < NUM_GROUPS; g++)
    begin : g_grp
        assign grp_waddr[g] = cam_base + AW'(ring_idx(grp_tail_reg[cam_reg][g]));

        rfbp_ram #(.WIDTH(SW), .DEPTH(TOTAL)) u_grp_ram (
            .clk   (clk),
            .we    (prod_commit),
            .waddr (grp_waddr[g]),
            .wdata (free_rdata),
            .raddr (grp_raddr),
            .rdata (grp_rdata[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CAMS; c++)
            begin
                free_head_reg[c] <= '0;
                free_tail_reg[c] <= PW'(SLOTS_PER_CAM);
                for (int g = 0; g < NUM_GROUPS; g++)
                begin
                    grp_head_reg[c][g] <= '0;
                    grp_tail_reg[c][g] <= '0;
                end
            end
            for (int r = 0; r < NRR; r++)
            begin
                rr_reg[r] <= '0;
            end
            sw_addr_reg   <= '0;
            sw_idx_reg    <= '0;
            kind_reg      <= '0;
            bad_reg       <= 1'b0;
            cam_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.sweep)
            begin
                sw_addr_reg <= sw_addr_reg + 1'b1;
                sw_idx_reg  <= (sw_idx_reg == SW'(SLOTS_PER_CAM - 1)) ? '0 : sw_idx_reg + 1'b1;
            end
            if (cmd.accept)
            begin
                kind_reg <= kind;
                bad_reg  <= acc_bad;
                cam_reg  <= acc_cam;
                k_reg    <= '0;
            end
            if (cmd.scan && !sts.scan_hit)
            begin
                cam_reg <= cam_next;
                k_reg   <= k_reg + 1'b1;
            end
            if (cmd.fetch)
            begin
                grp_head_reg[cam_reg][grp_reg] <= ptr_inc(sel_gh);
                rr_reg[rr_idx_reg]             <= cam_next;
            end
            if (prod_commit)
            begin
                free_head_reg[cam_reg] <= ptr_inc(fh);
                for (int g = 0; g < NUM_GROUPS; g++)
                begin
                    grp_tail_reg[cam_reg][g] <= ptr_inc(grp_tail_reg[cam_reg][g]);
                end
            end
            if (rel_commit && ref_rdata == REFS_W'(1) && !free_full)
            begin
                free_tail_reg[cam_reg] <= ptr_inc(ft);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            grp_reg    <= GW'(group);
            sid_reg    <= slot_in;
            rr_idx_reg <= acc_rr;
        end
        if (cmd.fetch)
        begin
            gid_reg <= fetch_gid;
        end
        if (cmd.check)
        begin
            res_slot_reg  <= '0;
            res_freed_reg <= 1'b0;
            res_refs_reg  <= '0;
            if (bad_reg)
                res_status_reg <= ST_INVALID;
            else if (free_empty)
                res_status_reg <= ST_EMPTY;
            else
                res_status_reg <= ST_OVERFLOW;
        end
        if (cmd.scan)
        begin
            res_status_reg <= ST_EMPTY;
        end
        if (cmd.fref)
        begin
            res_status_reg <= ST_OK;
            res_slot_reg   <= SLOT_W'(gid_reg);
            res_refs_reg   <= ref_rdata;
        end
        if (prod_commit)
        begin
            res_status_reg <= ST_OK;
            res_slot_reg   <= SLOT_W'(prod_gid);
            res_refs_reg   <= REFS_W'(NUM_GROUPS);
        end
        if (rel_commit)
        begin
            res_slot_reg <= '0;
            if (ref_rdata == '0)
            begin
                res_status_reg <= ST_INVALID;
                res_freed_reg  <= 1'b0;
                res_refs_reg   <= '0;
            end
            else if (ref_rdata == REFS_W'(1))
            begin
                if (free_full)
                begin
                    res_status_reg <= ST_OVERFLOW;
                    res_freed_reg  <= 1'b0;
                    res_refs_reg   <= ref_rdata;
                end
                else
                begin
                    res_status_reg <= ST_OK;
                    res_freed_reg  <= 1'b1;
                    res_refs_reg   <= '0;
                end
            end
            else
            begin
                res_status_reg <= ST_OK;
                res_freed_reg  <= 1'b0;
                res_refs_reg   <= ref_rdata - 1'b1;
            end
        end
        if (cmd.emit)
        begin
            status_reg    <= res_status_reg;
            slot_out_reg  <= res_slot_reg;
            freed_reg     <= res_freed_reg;
            refs_left_reg <= res_refs_reg;
        end
    end

    assign sts.sweep_last = (sw_addr_reg == AW'(TOTAL - 1));
    assign sts.is_produce = is_produce;
    assign sts.is_fetch   = is_fetch;
    assign sts.is_release = is_release;
    assign sts.bad        = bad_reg;
    assign sts.prod_fail  = free_empty || grp_full;
    assign sts.scan_hit   = (sel_gh != sel_gt);
    assign sts.scan_last  = (k_reg == CW'(NUM_CAMS - 1));
    assign sts.out_busy   = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot_out  = slot_out_reg;
    assign freed     = freed_reg;
    assign refs_left = refs_left_reg;

endmodule

@@ verif/refcounted_frame_buffer_pool_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// refcounted_frame_buffer_pool_unit_test: frame buffer pool block test
// Drives produce, fetch, release and invalid-kind transactions with random
// idling on both channels for part of the run, predicts every result with a
// local pool model and compares each returned result, all fields at once, in order.
// ----------------------------------------------------------------------------
module refcounted_frame_buffer_pool_unit_test;
    import rfbp_pkg::*;

    localparam int NCAM  = 6;
    localparam int NSLOT = 64;
    localparam int NGRP  = 3;
    localparam int NWRK  = 8;
    localparam int PMOD  = 2 * NSLOT;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [STAT_W-1:0] st;
        logic [SLOT_W-1:0] slot;
        logic              fr;
        logic [REFS_W-1:0] refs;
    } pool_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [KIND_W-1:0] kind;
    logic [CAM_W-1:0]  camera;
    logic [GRP_W-1:0]  group;
    logic [WRK_W-1:0]  worker;
    logic [SLOT_W-1:0] slot_in;
    logic out_valid;
    logic out_ready;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_out;
    logic freed;
    logic [REFS_W-1:0] refs_left;

    refcounted_frame_buffer_pool_unit dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .camera(camera), .group(group), .worker(worker),
        .slot_in(slot_in), .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .slot_out(slot_out), .freed(freed), .refs_left(refs_left)
    );

    // pool model state
    int free_ring_m [NCAM*NSLOT];
    int free_hd [NCAM];
    int free_tl [NCAM];
    int grp_ring_m [NCAM*NGRP*NSLOT];
    int grp_hd [NCAM*NGRP];
    int grp_tl [NCAM*NGRP];
    int refcnt [NCAM*NSLOT];
    int rr_ptr [NGRP*NWRK];

    pool_result_t pending_results[$];
    int held_slots[$];
    int errors;
    int cycles;
    bit idle_on;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int occ(int hd, int tl);
        return (tl + PMOD - hd) % PMOD;
    endfunction

    function automatic void pool_reset();
        for (int c = 0; c < NCAM; c++)
        begin
            for (int i = 0; i < NSLOT; i++)
                free_ring_m[c*NSLOT+i] = i;
            free_hd[c] = 0;
            free_tl[c] = NSLOT;
        end
        foreach (grp_hd[q])
        begin
            grp_hd[q] = 0;
            grp_tl[q] = 0;
        end
        foreach (refcnt[s])
            refcnt[s] = 0;
        foreach (rr_ptr[r])
            rr_ptr[r] = 0;
    endfunction

    function automatic pool_result_t pool_predict(logic [KIND_W-1:0] k, int c, int g,
                                                  int w, int sid);
        pool_result_t r;
        int q;
        int idx;
        int p;
        r = '0;
        if (k == KIND_PRODUCE)
        begin
            if (c >= NCAM)
            begin
                r.st = ST_INVALID;
                return r;
            end
            if (occ(free_hd[c], free_tl[c]) == 0)
            begin
                r.st = ST_EMPTY;
                return r;
            end
            for (int gg = 0; gg < NGRP; gg++)
                if (occ(grp_hd[c*NGRP+gg], grp_tl[c*NGRP+gg]) >= NSLOT)
                begin
                    r.st = ST_OVERFLOW;
                    return r;
                end
            idx = free_ring_m[c*NSLOT + free_hd[c] % NSLOT] % NSLOT;
            free_hd[c] = (free_hd[c] + 1) % PMOD;
            refcnt[c*NSLOT+idx] = NGRP;
            for (int gg = 0; gg < NGRP; gg++)
            begin
                q = c*NGRP + gg;
                grp_ring_m[q*NSLOT + grp_tl[q] % NSLOT] = idx;
                grp_tl[q] = (grp_tl[q] + 1) % PMOD;
            end
            r.st = ST_OK;
            r.slot = SLOT_W'(c*NSLOT + idx);
            r.refs = REFS_W'(NGRP);
            return r;
        end
        if (k == KIND_FETCH)
        begin
            if (g >= NGRP || w >= NWRK)
            begin
                r.st = ST_INVALID;
                return r;
            end
            p = rr_ptr[g*NWRK+w] % NCAM;
            for (int i = 0; i < NCAM; i++)
            begin
                c = (p + i) % NCAM;
                q = c*NGRP + g;
                if (occ(grp_hd[q], grp_tl[q]) != 0)
                begin
                    idx = grp_ring_m[q*NSLOT + grp_hd[q] % NSLOT] % NSLOT;
                    grp_hd[q] = (grp_hd[q] + 1) % PMOD;
                    rr_ptr[g*NWRK+w] = (c + 1) % NCAM;
                    r.st = ST_OK;
                    r.slot = SLOT_W'(c*NSLOT + idx);
                    r.refs = REFS_W'(refcnt[c*NSLOT+idx]);
                    return r;
                end
            end
            r.st = ST_EMPTY;
            return r;
        end
        if (k == KIND_RELEASE)
        begin
            if (sid >= NCAM*NSLOT || refcnt[sid] == 0)
            begin
                r.st = ST_INVALID;
                return r;
            end
            if (refcnt[sid] == 1)
            begin
                c = sid / NSLOT;
                if (occ(free_hd[c], free_tl[c]) >= NSLOT)
                begin
                    r.st = ST_OVERFLOW;
                    r.refs = REFS_W'(1);
                    return r;
                end
                free_ring_m[c*NSLOT + free_tl[c] % NSLOT] = sid % NSLOT;
                free_tl[c] = (free_tl[c] + 1) % PMOD;
                refcnt[sid] = 0;
                r.st = ST_OK;
                r.fr = 1'b1;
                return r;
            end
            refcnt[sid] = refcnt[sid] - 1;
            r.st = ST_OK;
            r.refs = REFS_W'(refcnt[sid]);
            return r;
        end
        r.st = ST_INVALID;
        return r;
    endfunction

    task automatic send_transaction(logic [KIND_W-1:0] k, int c, int g, int w, int sid);
        pool_result_t r;
        logic [CAM_W-1:0]  cv;
        logic [GRP_W-1:0]  gv;
        logic [WRK_W-1:0]  wv;
        logic [SLOT_W-1:0] sv;
        cv = CAM_W'(c);
        gv = GRP_W'(g);
        wv = WRK_W'(w);
        sv = SLOT_W'(sid);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        camera <= cv;
        group <= gv;
        worker <= wv;
        slot_in <= sv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = pool_predict(k, int'(cv), int'(gv), int'(wv), int'(sv));
        pending_results.push_back(r);
        if (k == KIND_PRODUCE && r.st == ST_OK)
            held_slots.push_back(int'(r.slot));
        if (k == KIND_FETCH && r.st == ST_OK)
            held_slots.push_back(int'(r.slot));
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        pool_result_t want;
        if (out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result st=%0d slot=%0d", $time, status, slot_out);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (want != {status, slot_out, freed, refs_left})
                begin
                    $display("%0t mismatch expected st=%0d slot=%0d freed=%0d refs=%0d",
                             $time, want.st, want.slot, want.fr, want.refs);
                    $display("%0t          actual   st=%0d slot=%0d freed=%0d refs=%0d",
                             $time, status, slot_out, freed, refs_left);
                    errors++;
                end
            end
        end
    end

    initial begin
        int burst;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                burst = $urandom_range(1, 18);
                repeat (burst) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic release_random();
        int i;
        if (held_slots.size() == 0 || $urandom_range(0, 9) == 0)
            send_transaction(KIND_RELEASE, 0, 0, 0, $urandom_range(0, 511));
        else
        begin
            i = $urandom_range(0, held_slots.size() - 1);
            send_transaction(KIND_RELEASE, 0, 0, 0, held_slots[i]);
            held_slots.delete(i);
        end
    endtask

    task automatic test_directed();
        send_transaction(KIND_FETCH, 0, 0, 0, 0);
        send_transaction(KIND_RELEASE, 0, 0, 0, 0);
        send_transaction(KIND_RELEASE, 7, 3, 7, 511);
        send_transaction(2'd3, 7, 3, 7, 511);
        send_transaction(KIND_PRODUCE, 7, 0, 0, 0);
        send_transaction(KIND_PRODUCE, 6, 0, 0, 0);
        send_transaction(KIND_PRODUCE, 0, 0, 0, 0);
        send_transaction(KIND_PRODUCE, 5, 0, 0, 0);
        send_transaction(KIND_FETCH, 0, 3, 0, 0);
        send_transaction(KIND_FETCH, 0, 2, 7, 0);
        send_transaction(KIND_FETCH, 0, 2, 7, 0);
        send_transaction(KIND_FETCH, 0, 2, 7, 0);
        send_transaction(KIND_FETCH, 0, 0, 0, 0);
        send_transaction(KIND_FETCH, 0, 1, 3, 0);
        send_transaction(KIND_RELEASE, 0, 0, 0, 0);
        send_transaction(KIND_RELEASE, 0, 0, 0, 0);
        send_transaction(KIND_RELEASE, 0, 0, 0, 0);
        send_transaction(KIND_RELEASE, 0, 0, 0, 0);
        send_transaction(KIND_RELEASE, 0, 0, 0, 383);
        send_transaction(KIND_RELEASE, 0, 0, 0, 384);
        held_slots.delete();
    endtask

    // drain camera 1 free ring, refill it by releases, then hit full group FIFOs
    task automatic test_exhaust();
        for (int i = 0; i < NSLOT + 1; i++)
            send_transaction(KIND_PRODUCE, 1, 0, 0, 0);
        for (int s = NSLOT; s < 2*NSLOT; s++)
            for (int j = 0; j < NGRP; j++)
                send_transaction(KIND_RELEASE, 0, 0, 0, s);
        send_transaction(KIND_PRODUCE, 1, 0, 0, 0);
        for (int i = 0; i < 3*NSLOT + 4; i++)
            send_transaction(KIND_FETCH, 0, i % NGRP, $urandom_range(0, 7), 0);
        held_slots.delete();
    endtask

    task automatic test_random(int count);
        int sel;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 35)
                send_transaction(KIND_PRODUCE, $urandom_range(0, 6), $urandom, $urandom, $urandom);
            else if (sel < 65)
                send_transaction(KIND_FETCH, $urandom, $urandom_range(0, 3),
                                 $urandom_range(0, 7), $urandom);
            else if (sel < 97)
                release_random();
            else
                send_transaction(2'd3, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        int wait_cycles;
        errors = 0;
        cycles = 0;
        idle_on = 1'b1;
        in_valid = 1'b0;
        kind = '0;
        camera = '0;
        group = '0;
        worker = '0;
        slot_in = '0;
        rst_n = 1'b0;
        pool_reset();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_exhaust();
        test_random(430);
        idle_on = 1'b0;
        test_random(150);
        in_valid <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
